[rtl/core/aes_pkg.sv]
`timescale 1ns / 1ps
package aes_pkg;

  localparam int MaxRoundsDef = 14;
  localparam int MinRounds    = 10;

  // APB byte address of the round count register
  localparam logic [1:0] RegRoundCount = 2'd0;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ENC  = 2'd1,
    ACT_DEC  = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_KEY0  = 2'd1,
    ST_ROUND = 2'd2,
    ST_OUT   = 2'd3
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_block;  // capture input block
    logic first_key;   // xor first round key into loaded block
    logic do_round;    // run one round
    logic last_round;  // round without mix columns
    logic decrypt;
    logic emit;        // move state to output register
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

[rtl/core/aes_ctrl.sv]
`timescale 1ns / 1ps
module aes_ctrl import aes_pkg::*; #(
  parameter int MaxRounds = MaxRoundsDef,
  localparam int SlotW = $clog2(MaxRounds + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [1:0]       action_i,
  input  logic [3:0]       round_count_i,
  input  logic             out_busy_i,
  output logic             in_ready_o,
  output logic [SlotW-1:0] key_addr_o,
  output dp_cmd_t          cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [SlotW-1:0] nr_q, nr_d, rnd_q, rnd_d;
  logic dec_q, dec_d;
  logic [SlotW-1:0] nr_clamp;

  always_comb begin
    if (round_count_i < 4'(MinRounds)) begin
      nr_clamp = SlotW'(MinRounds);
    end else if ({1'b0, round_count_i} > 5'(MaxRounds)) begin
      nr_clamp = SlotW'(MaxRounds);
    end else begin
      nr_clamp = SlotW'(round_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nr_q    <= '0;
      rnd_q   <= '0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      nr_q    <= nr_d;
      rnd_q   <= rnd_d;
      dec_q   <= dec_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    nr_d       = nr_q;
    rnd_d      = rnd_q;
    dec_d      = dec_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.decrypt = dec_q;
    // address the key of the next step: round rnd+1 reads rnd+1 (enc) or nr-rnd-1 (dec)
    key_addr_o = dec_q ? (nr_q - rnd_q - SlotW'(1)) : (rnd_q + SlotW'(1));
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        // first key add reads slot 0 (enc) or slot nr (dec)
        key_addr_o = (action_i == ACT_DEC) ? nr_clamp : '0;
        if (in_fire_i && (action_i == ACT_ENC || action_i == ACT_DEC)) begin
          cmd_o.load_block = 1'b1;
          nr_d  = nr_clamp;
          dec_d = (action_i == ACT_DEC);
          rnd_d = '0;
          state_d = ST_KEY0;
        end
      end
      ST_KEY0: begin
        cmd_o.first_key = 1'b1;
        rnd_d   = SlotW'(1);
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.do_round   = 1'b1;
        cmd_o.last_round = (rnd_q == nr_q);
        rnd_d = rnd_q + SlotW'(1);
        if (rnd_q == nr_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/aes_datapath.sv]
`timescale 1ns / 1ps
module aes_datapath import aes_pkg::*; #(
  parameter int MaxRounds = MaxRoundsDef,
  localparam int SlotW = $clog2(MaxRounds + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             key_we_i,
  input  logic [3:0]       key_slot_i,
  input  logic [127:0]     data_i,
  input  logic [SlotW-1:0] key_addr_i,
  input  dp_cmd_t          cmd_i,
  input  logic             out_take_i,
  output logic             out_valid_o,
  output logic [127:0]     result_o
);

  // key store, undefined until loaded
  logic [127:0] key_mem [MaxRounds+1];
  logic [127:0] key_rd_q;
  logic [127:0] state_q, state_d;
  logic [127:0] res_q;
  logic         out_valid_q;

  always_ff @(posedge clk_i) begin
    if (key_we_i && ({1'b0, key_slot_i} <= 5'(MaxRounds))) begin
      key_mem[key_slot_i[SlotW-1:0]] <= data_i;
    end
  end

  // key read registered; controller presents address one step ahead
  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[key_addr_i];
  end

  // byte p of state at bits [127-8p -: 8]
  logic [7:0] b   [16];
  logic [7:0] sb  [16];
  logic [7:0] sr  [16];
  logic [7:0] mc  [16];
  logic [127:0] rnd_out;

  always_comb begin
    for (int p = 0; p < 16; p++) begin
      b[p]  = state_q[127-8*p -: 8];
      sb[p] = cmd_i.decrypt ? INV_SBOX[b[p]] : SBOX[b[p]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (cmd_i.decrypt) begin
          sr[c*4+r] = sb[((c + 4 - r) & 3)*4 + r];
        end else begin
          sr[c*4+r] = sb[((c + r) & 3)*4 + r];
        end
      end
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, x1, x2, x4, x8;
        a0 = sr[c*4 + r];
        a1 = sr[c*4 + ((r+1)&3)];
        a2 = sr[c*4 + ((r+2)&3)];
        a3 = sr[c*4 + ((r+3)&3)];
        if (cmd_i.decrypt) begin
          // 0e a0 ^ 0b a1 ^ 0d a2 ^ 09 a3
          x1 = a0 ^ a1 ^ a2 ^ a3;
          x2 = xtime(a0 ^ a1);
          x4 = xtime(xtime(a0 ^ a2));
          x8 = xtime(xtime(xtime(x1)));
          mc[c*4+r] = x8 ^ x4 ^ x2 ^ a1 ^ a2 ^ a3;
        end else begin
          x1 = a0 ^ a1 ^ a2 ^ a3;
          x2 = xtime(a0 ^ a1);
          x4 = '0;
          x8 = '0;
          mc[c*4+r] = x2 ^ a1 ^ a2 ^ a3 ^ x4 ^ x8 ^ (x1 & 8'h00);
        end
      end
    end
    for (int p = 0; p < 16; p++) begin
      rnd_out[127-8*p -: 8] = cmd_i.last_round ? sr[p] : mc[p];
    end
  end

  always_comb begin
    state_d = state_q;
    if (cmd_i.load_block) begin
      state_d = data_i;
    end else if (cmd_i.first_key) begin
      state_d = state_q ^ key_rd_q;
    end else if (cmd_i.do_round) begin
      state_d = rnd_out ^ key_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    if (cmd_i.emit) begin
      res_q <= state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_take_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

[rtl/core/aes_block_encrypt_decrypt.sv]
`timescale 1ns / 1ps
// Channel   | Dir | tdata fields (low bit up)                         | tuser
// s_axis    | in  | key_slot[3:0], data_high[67:4], data_low[131:68]  | action[1:0]
// m_axis    | out | result_high[63:0], result_low[127:64]             | -
// apb       | in  | reg 0 at 0x0: round_count[3:0]                    | -
//
// A key load is one accepted beat. A block steps through load, first key add,
// one round per cycle through the shared round datapath, then the emit
// step that moves the state to the output register.
// The key store read port is registered and is addressed one step ahead.
// Reset clears control only; the key store holds garbage until loaded.
// The output register frees the core: a stalled m_axis holds only the
// emit step until the previous beat is taken.
module aes_block_encrypt_decrypt import aes_pkg::*; #(
  parameter int MaxRounds = MaxRoundsDef,
  localparam int SlotW = $clog2(MaxRounds + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [135:0]   s_axis_tdata,   // key_slot, data_high, data_low, pad
  input  logic [1:0]     s_axis_tuser,   // action
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [127:0]   m_axis_tdata,   // result_high, result_low
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic [3:0] round_count_q;
  logic       in_fire;
  logic [127:0] blk;
  logic [127:0] res;
  logic [SlotW-1:0] key_addr;
  dp_cmd_t cmd;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= 4'(MinRounds);
    end else if (psel && penable && pwrite && paddr == RegRoundCount) begin
      round_count_q <= pwdata[3:0];
    end
  end
  assign prdata = (paddr == RegRoundCount) ? {28'd0, round_count_q} : 32'd0;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  // data_high carries block bytes 0..7 -> state bits [127:64]
  assign blk = {s_axis_tdata[67:4], s_axis_tdata[131:68]};

  aes_ctrl #(.MaxRounds(MaxRounds)) u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i     (in_fire),
    .action_i      (s_axis_tuser),
    .round_count_i (round_count_q),
    .out_busy_i    (m_axis_tvalid && !m_axis_tready),
    .in_ready_o    (s_axis_tready),
    .key_addr_o    (key_addr),
    .cmd_o         (cmd)
  );

  aes_datapath #(.MaxRounds(MaxRounds)) u_dp (
    .clk_i, .rst_ni,
    .key_we_i    (in_fire && s_axis_tuser == ACT_LOAD),
    .key_slot_i  (s_axis_tdata[3:0]),
    .data_i      (blk),
    .key_addr_i  (key_addr),
    .cmd_i       (cmd),
    .out_take_i  (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .result_o    (res)
  );

  assign m_axis_tdata = {res[63:0], res[127:64]};

endmodule

[rtl/core/aes_checker.sv]
`timescale 1ns / 1ps
module aes_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         pready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input side idle");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
    else $error("input beat withdrawn before accept");

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind aes_block_encrypt_decrypt aes_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .pready
);
